// File: rtl/imu_pkg.sv
// Shared types, codes, arithmetic helpers and the sequencer program of the orientation filter.
package imu_pkg;

    // Register file address and word
    typedef logic [4:0]  t_ra;
    typedef logic [63:0] t_word;
    typedef logic [6:0]  t_pc;

    // Operation codes
    localparam logic [2:0] OP_MAC   = 3'd0;
    localparam logic [2:0] OP_SQRT  = 3'd1;
    localparam logic [2:0] OP_DIV   = 3'd2;
    localparam logic [2:0] OP_SKIPZ = 3'd3;
    localparam logic [2:0] OP_STQ   = 3'd4;
    localparam logic [2:0] OP_DONE  = 3'd5;

    // Rounding shift applied to a product before accumulation
    localparam logic [1:0] PR_0  = 2'd0;
    localparam logic [1:0] PR_12 = 2'd1;
    localparam logic [1:0] PR_16 = 2'd2;
    localparam logic [1:0] PR_30 = 2'd3;

    // Shift applied to the finished sum
    localparam logic [1:0] PO_NONE = 2'd0;
    localparam logic [1:0] PO_R6   = 2'd1;
    localparam logic [1:0] PO_R13  = 2'd2;
    localparam logic [1:0] PO_L30  = 2'd3;

    // Term weights
    localparam logic [2:0] CF_P1 = 3'd0;
    localparam logic [2:0] CF_M1 = 3'd1;
    localparam logic [2:0] CF_P2 = 3'd2;
    localparam logic [2:0] CF_M2 = 3'd3;
    localparam logic [2:0] CF_P4 = 3'd4;
    localparam logic [2:0] CF_M4 = 3'd5;
    localparam logic [2:0] CF_P8 = 3'd6;

    // Saturation limits
    localparam logic [1:0] SAT_NONE = 2'd0;
    localparam logic [1:0] SAT_S36  = 2'd1;
    localparam logic [1:0] SAT_SN   = 2'd2;
    localparam logic [1:0] SAT_QN   = 2'd3;

    // Numerator scaling for divisions
    localparam logic [1:0] DK_45 = 2'd0;
    localparam logic [1:0] DK_24 = 2'd1;
    localparam logic [1:0] DK_30 = 2'd2;

    // Register file map
    localparam t_ra R_G0   = 5'd0;
    localparam t_ra R_G1   = 5'd1;
    localparam t_ra R_G2   = 5'd2;
    localparam t_ra R_AX   = 5'd3;
    localparam t_ra R_AY   = 5'd4;
    localparam t_ra R_AZ   = 5'd5;
    localparam t_ra R_DT   = 5'd6;
    localparam t_ra R_BETA = 5'd7;
    localparam t_ra R_Q0   = 5'd8;
    localparam t_ra R_Q1   = 5'd9;
    localparam t_ra R_Q2   = 5'd10;
    localparam t_ra R_Q3   = 5'd11;
    localparam t_ra R_SUM  = 5'd12;
    localparam t_ra R_NORM = 5'd13;
    localparam t_ra R_AN0  = 5'd14;  // normalized accel, later half rates
    localparam t_ra R_AN1  = 5'd15;
    localparam t_ra R_AN2  = 5'd16;
    localparam t_ra R_Q00  = 5'd17;  // q0 squared, later half rate 3
    localparam t_ra R_Q11  = 5'd18;
    localparam t_ra R_Q22  = 5'd19;
    localparam t_ra R_Q33  = 5'd20;
    localparam t_ra R_S0   = 5'd21;  // gradient, later rate
    localparam t_ra R_S1   = 5'd22;
    localparam t_ra R_S2   = 5'd23;
    localparam t_ra R_S3   = 5'd24;
    localparam t_ra R_W0   = 5'd25;  // Q24 gradient, normalized gradient, new q
    localparam t_ra R_W1   = 5'd26;
    localparam t_ra R_W2   = 5'd27;
    localparam t_ra R_W3   = 5'd28;
    localparam t_ra R_ONE  = 5'd29;

    // Index of the last input load step, which writes the unit constant
    localparam logic [3:0] LOAD_LAST = 4'd12;

    typedef struct packed {
        logic [2:0] op;
        t_ra        ra;
        t_ra        rb;
        t_ra        rd;
        logic [1:0] pre;
        logic [1:0] post;
        logic [2:0] coef;
        logic       first;
        logic       last;
        logic [1:0] sat;
        logic [1:0] dk;
    } t_uop;

    // Divide by 2^k, rounded to nearest, ties away from zero
    function automatic logic signed [79:0] rnd_shr(input logic signed [79:0] v,
                                                  input logic [4:0] k);
        logic        neg;
        logic [79:0] m;
        neg = v[79];
        m   = neg ? 80'(-v) : 80'(v);
        if (k != 5'd0) begin
            m = (m + (80'd1 << (k - 5'd1))) >> k;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Symmetric clamp
    function automatic logic signed [79:0] sat_v(input logic signed [79:0] v,
                                                input logic [1:0] c);
        logic signed [79:0] lim;
        case (c)
            SAT_S36: lim = (80'sd1 <<< 36) - 80'sd1;
            SAT_SN:  lim = 80'sd1 <<< 31;
            SAT_QN:  lim = (80'sd1 <<< 31) - 80'sd1;
            default: lim = 80'sd0;
        endcase
        if (c == SAT_NONE) begin
            return v;
        end
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic t_uop u_mac(input t_ra a, input t_ra b, input logic [1:0] pre,
                                   input logic [2:0] cf, input logic f, input logic l,
                                   input logic [1:0] po, input logic [1:0] st,
                                   input t_ra d);
        t_uop u;
        u       = '0;
        u.op    = OP_MAC;
        u.ra    = a;
        u.rb    = b;
        u.pre   = pre;
        u.coef  = cf;
        u.first = f;
        u.last  = l;
        u.post  = po;
        u.sat   = st;
        u.rd    = d;
        return u;
    endfunction

    function automatic t_uop u_op(input logic [2:0] op, input t_ra a, input t_ra b,
                                  input t_ra d, input logic [1:0] st, input logic [1:0] dk);
        t_uop u;
        u     = '0;
        u.op  = op;
        u.ra  = a;
        u.rb  = b;
        u.rd  = d;
        u.sat = st;
        u.dk  = dk;
        return u;
    endfunction

    // Filter program
    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        case (pc)
            // accel norm and zero test
            7'd0:  u = u_mac(R_AX, R_AX, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd1:  u = u_mac(R_AY, R_AY, PR_0, CF_P1, 1'b0, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd2:  u = u_mac(R_AZ, R_AZ, PR_0, CF_P1, 1'b0, 1'b1, PO_L30, SAT_NONE, R_SUM);
            7'd3:  u = u_op(OP_SKIPZ, R_SUM, R_SUM, R_SUM, SAT_NONE, DK_45);
            7'd4:  u = u_op(OP_SQRT, R_SUM, R_SUM, R_NORM, SAT_NONE, DK_45);
            7'd5:  u = u_op(OP_DIV, R_AX, R_NORM, R_AN0, SAT_NONE, DK_45);
            7'd6:  u = u_op(OP_DIV, R_AY, R_NORM, R_AN1, SAT_NONE, DK_45);
            7'd7:  u = u_op(OP_DIV, R_AZ, R_NORM, R_AN2, SAT_NONE, DK_45);
            // squares of q
            7'd8:  u = u_mac(R_Q0, R_Q0, PR_30, CF_P1, 1'b1, 1'b1, PO_NONE, SAT_NONE, R_Q00);
            7'd9:  u = u_mac(R_Q1, R_Q1, PR_30, CF_P1, 1'b1, 1'b1, PO_NONE, SAT_NONE, R_Q11);
            7'd10: u = u_mac(R_Q2, R_Q2, PR_30, CF_P1, 1'b1, 1'b1, PO_NONE, SAT_NONE, R_Q22);
            7'd11: u = u_mac(R_Q3, R_Q3, PR_30, CF_P1, 1'b1, 1'b1, PO_NONE, SAT_NONE, R_Q33);
            // gradient s0
            7'd12: u = u_mac(R_Q0, R_Q22, PR_30, CF_P4, 1'b1, 1'b0, PO_NONE, SAT_S36, R_S0);
            7'd13: u = u_mac(R_Q2, R_AN0, PR_30, CF_P2, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S0);
            7'd14: u = u_mac(R_Q0, R_Q11, PR_30, CF_P4, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S0);
            7'd15: u = u_mac(R_Q1, R_AN1, PR_30, CF_M2, 1'b0, 1'b1, PO_NONE, SAT_S36, R_S0);
            // gradient s1
            7'd16: u = u_mac(R_Q1, R_Q33, PR_30, CF_P4, 1'b1, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd17: u = u_mac(R_Q3, R_AN0, PR_30, CF_M2, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd18: u = u_mac(R_Q00, R_Q1, PR_30, CF_P4, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd19: u = u_mac(R_Q0, R_AN1, PR_30, CF_M2, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd20: u = u_mac(R_Q1, R_ONE, PR_0, CF_M4, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd21: u = u_mac(R_Q1, R_Q11, PR_30, CF_P8, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd22: u = u_mac(R_Q1, R_Q22, PR_30, CF_P8, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S1);
            7'd23: u = u_mac(R_Q1, R_AN2, PR_30, CF_P4, 1'b0, 1'b1, PO_NONE, SAT_S36, R_S1);
            // gradient s2
            7'd24: u = u_mac(R_Q00, R_Q2, PR_30, CF_P4, 1'b1, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd25: u = u_mac(R_Q0, R_AN0, PR_30, CF_P2, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd26: u = u_mac(R_Q2, R_Q33, PR_30, CF_P4, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd27: u = u_mac(R_Q3, R_AN1, PR_30, CF_M2, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd28: u = u_mac(R_Q2, R_ONE, PR_0, CF_M4, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd29: u = u_mac(R_Q2, R_Q11, PR_30, CF_P8, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd30: u = u_mac(R_Q2, R_Q22, PR_30, CF_P8, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S2);
            7'd31: u = u_mac(R_Q2, R_AN2, PR_30, CF_P4, 1'b0, 1'b1, PO_NONE, SAT_S36, R_S2);
            // gradient s3
            7'd32: u = u_mac(R_Q11, R_Q3, PR_30, CF_P4, 1'b1, 1'b0, PO_NONE, SAT_S36, R_S3);
            7'd33: u = u_mac(R_Q1, R_AN0, PR_30, CF_M2, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S3);
            7'd34: u = u_mac(R_Q22, R_Q3, PR_30, CF_P4, 1'b0, 1'b0, PO_NONE, SAT_S36, R_S3);
            7'd35: u = u_mac(R_Q2, R_AN1, PR_30, CF_M2, 1'b0, 1'b1, PO_NONE, SAT_S36, R_S3);
            // gradient in Q24
            7'd36: u = u_mac(R_S0, R_ONE, PR_0, CF_P1, 1'b1, 1'b1, PO_R6, SAT_NONE, R_W0);
            7'd37: u = u_mac(R_S1, R_ONE, PR_0, CF_P1, 1'b1, 1'b1, PO_R6, SAT_NONE, R_W1);
            7'd38: u = u_mac(R_S2, R_ONE, PR_0, CF_P1, 1'b1, 1'b1, PO_R6, SAT_NONE, R_W2);
            7'd39: u = u_mac(R_S3, R_ONE, PR_0, CF_P1, 1'b1, 1'b1, PO_R6, SAT_NONE, R_W3);
            // gradient norm
            7'd40: u = u_mac(R_W0, R_W0, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd41: u = u_mac(R_W1, R_W1, PR_0, CF_P1, 1'b0, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd42: u = u_mac(R_W2, R_W2, PR_0, CF_P1, 1'b0, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd43: u = u_mac(R_W3, R_W3, PR_0, CF_P1, 1'b0, 1'b1, PO_NONE, SAT_NONE, R_SUM);
            7'd44: u = u_op(OP_SQRT, R_SUM, R_SUM, R_NORM, SAT_NONE, DK_24);
            // normalized gradient, a zero norm passes the term through
            7'd45: u = u_op(OP_DIV, R_S0, R_NORM, R_W0, SAT_SN, DK_24);
            7'd46: u = u_op(OP_DIV, R_S1, R_NORM, R_W1, SAT_SN, DK_24);
            7'd47: u = u_op(OP_DIV, R_S2, R_NORM, R_W2, SAT_SN, DK_24);
            7'd48: u = u_op(OP_DIV, R_S3, R_NORM, R_W3, SAT_SN, DK_24);
            // gyro half rates
            7'd49: u = u_mac(R_Q1, R_G0, PR_0, CF_M1, 1'b1, 1'b0, PO_R13, SAT_NONE, R_AN0);
            7'd50: u = u_mac(R_Q2, R_G1, PR_0, CF_M1, 1'b0, 1'b0, PO_R13, SAT_NONE, R_AN0);
            7'd51: u = u_mac(R_Q3, R_G2, PR_0, CF_M1, 1'b0, 1'b1, PO_R13, SAT_NONE, R_AN0);
            7'd52: u = u_mac(R_Q0, R_G0, PR_0, CF_P1, 1'b1, 1'b0, PO_R13, SAT_NONE, R_AN1);
            7'd53: u = u_mac(R_Q2, R_G2, PR_0, CF_P1, 1'b0, 1'b0, PO_R13, SAT_NONE, R_AN1);
            7'd54: u = u_mac(R_Q3, R_G1, PR_0, CF_M1, 1'b0, 1'b1, PO_R13, SAT_NONE, R_AN1);
            7'd55: u = u_mac(R_Q0, R_G1, PR_0, CF_P1, 1'b1, 1'b0, PO_R13, SAT_NONE, R_AN2);
            7'd56: u = u_mac(R_Q1, R_G2, PR_0, CF_M1, 1'b0, 1'b0, PO_R13, SAT_NONE, R_AN2);
            7'd57: u = u_mac(R_Q3, R_G0, PR_0, CF_P1, 1'b0, 1'b1, PO_R13, SAT_NONE, R_AN2);
            7'd58: u = u_mac(R_Q0, R_G2, PR_0, CF_P1, 1'b1, 1'b0, PO_R13, SAT_NONE, R_Q00);
            7'd59: u = u_mac(R_Q1, R_G1, PR_0, CF_P1, 1'b0, 1'b0, PO_R13, SAT_NONE, R_Q00);
            7'd60: u = u_mac(R_Q2, R_G0, PR_0, CF_M1, 1'b0, 1'b1, PO_R13, SAT_NONE, R_Q00);
            // rate minus weighted correction
            7'd61: u = u_mac(R_AN0, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_S0);
            7'd62: u = u_mac(R_BETA, R_W0, PR_12, CF_M1, 1'b0, 1'b1, PO_NONE, SAT_NONE, R_S0);
            7'd63: u = u_mac(R_AN1, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_S1);
            7'd64: u = u_mac(R_BETA, R_W1, PR_12, CF_M1, 1'b0, 1'b1, PO_NONE, SAT_NONE, R_S1);
            7'd65: u = u_mac(R_AN2, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_S2);
            7'd66: u = u_mac(R_BETA, R_W2, PR_12, CF_M1, 1'b0, 1'b1, PO_NONE, SAT_NONE, R_S2);
            7'd67: u = u_mac(R_Q00, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_S3);
            7'd68: u = u_mac(R_BETA, R_W3, PR_12, CF_M1, 1'b0, 1'b1, PO_NONE, SAT_NONE, R_S3);
            // integrate over the time step
            7'd69: u = u_mac(R_Q0, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_QN, R_W0);
            7'd70: u = u_mac(R_S0, R_DT, PR_16, CF_P1, 1'b0, 1'b1, PO_NONE, SAT_QN, R_W0);
            7'd71: u = u_mac(R_Q1, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_QN, R_W1);
            7'd72: u = u_mac(R_S1, R_DT, PR_16, CF_P1, 1'b0, 1'b1, PO_NONE, SAT_QN, R_W1);
            7'd73: u = u_mac(R_Q2, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_QN, R_W2);
            7'd74: u = u_mac(R_S2, R_DT, PR_16, CF_P1, 1'b0, 1'b1, PO_NONE, SAT_QN, R_W2);
            7'd75: u = u_mac(R_Q3, R_ONE, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_QN, R_W3);
            7'd76: u = u_mac(R_S3, R_DT, PR_16, CF_P1, 1'b0, 1'b1, PO_NONE, SAT_QN, R_W3);
            // renormalize
            7'd77: u = u_mac(R_W0, R_W0, PR_0, CF_P1, 1'b1, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd78: u = u_mac(R_W1, R_W1, PR_0, CF_P1, 1'b0, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd79: u = u_mac(R_W2, R_W2, PR_0, CF_P1, 1'b0, 1'b0, PO_NONE, SAT_NONE, R_SUM);
            7'd80: u = u_mac(R_W3, R_W3, PR_0, CF_P1, 1'b0, 1'b1, PO_NONE, SAT_NONE, R_SUM);
            7'd81: u = u_op(OP_SQRT, R_SUM, R_SUM, R_NORM, SAT_NONE, DK_30);
            7'd82: u = u_op(OP_SKIPZ, R_NORM, R_NORM, R_NORM, SAT_NONE, DK_30);
            7'd83: u = u_op(OP_DIV, R_W0, R_NORM, R_Q0, SAT_QN, DK_30);
            7'd84: u = u_op(OP_DIV, R_W1, R_NORM, R_Q1, SAT_QN, DK_30);
            7'd85: u = u_op(OP_DIV, R_W2, R_NORM, R_Q2, SAT_QN, DK_30);
            7'd86: u = u_op(OP_DIV, R_W3, R_NORM, R_Q3, SAT_QN, DK_30);
            // commit orientation
            7'd87: u = u_op(OP_STQ, R_Q0, R_Q0, 5'd0, SAT_NONE, DK_30);
            7'd88: u = u_op(OP_STQ, R_Q1, R_Q1, 5'd1, SAT_NONE, DK_30);
            7'd89: u = u_op(OP_STQ, R_Q2, R_Q2, 5'd2, SAT_NONE, DK_30);
            7'd90: u = u_op(OP_STQ, R_Q3, R_Q3, 5'd3, SAT_NONE, DK_30);
            default: u = u_op(OP_DONE, R_Q0, R_Q0, R_Q0, SAT_NONE, DK_30);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/imu_if.sv
// Handshake channels of the orientation filter: sample in, orientation out, gain write.
interface imu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [15:0] time_step;
    modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    time_step, input ready);
    modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  time_step, output ready);
endinterface

interface imu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               updated;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, updated, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, updated, output ready);
endinterface

interface imu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] beta_gain;
    modport source (output valid, beta_gain, input ready);
    modport sink (input valid, beta_gain, output ready);
endinterface

// File: rtl/imu_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit quotient.
module imu_div
    import imu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [32:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [32:0] r_num;
    logic [32:0] r_quo;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic        w_ge;

    // trial subtract
    assign w_sh = {r_rem, r_num[32]};
    assign w_ge = w_sh >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, the top bits of the dividend are known to lie below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[63:33]};
            r_num <= i_dividend[32:0];
            r_quo <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_sh - {1'b0, r_den}) : w_sh[31:0];
            r_num <= {r_num[31:0], 1'b0};
            r_quo <= {r_quo[31:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/imu_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
module imu_sqrt
    import imu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_try;

    assign w_try = r_res + r_bit;

    // control: 32 steps, the last one with the lowest bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 64'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // digit-by-digit root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= w_try) begin
                r_v   <= r_v - w_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// File: rtl/imu_orientation_fusion.sv
// Top level of the six-axis orientation filter: sequencer, shared multiplier, register file.
//
// Six-axis gradient-descent orientation filter. Each sample (gyro Q4.12, raw accel, time
// step Q0.16) updates the held orientation quaternion (Q2.30, identity after reset) and
// produces one result carrying the new quaternion and an updated flag; a zero accel vector
// returns the held quaternion with the flag clear. One sample occupies the block for the load
// steps and a program of 71 multiply-accumulate steps through a single multiplier and a
// 32-entry register file, 11 divisions in a bit-serial divider and 3 square roots. A
// gradient with zero norm skips its 4 divisions. A sample with zero acceleration ends at
// the zero test. The sample channel is ready only between samples; the result sits in an
// output register, so the next sample is taken while it waits. The gain register may be
// written at any time the block is idle.
module imu_orientation_fusion
    import imu_pkg::*;
#(
    parameter logic [15:0] BETA_RESET = 16'd410
)(
    input  logic     i_clk,
    input  logic     i_rst_n,
    imu_in_if.sink   i_sample,
    imu_cfg_if.sink  i_cfg,
    imu_out_if.source o_result
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EX   = 3'd3;
    localparam logic [2:0] S_AC   = 3'd4;
    localparam logic [2:0] S_WDV  = 3'd5;
    localparam logic [2:0] S_WSQ  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]         r_st;
    t_pc                r_pc;
    logic [3:0]         r_lc;
    logic               r_upd;
    logic [15:0]        r_beta;
    logic signed [31:0] r_q [4];
    logic signed [15:0] r_gx, r_gy, r_gz, r_ax, r_ay, r_az;
    logic [15:0]        r_dt;
    t_word              r_rf [32];
    t_word              r_rda, r_rdb;
    logic signed [73:0] r_prod;
    logic signed [79:0] r_acc;
    logic               r_ov;
    logic signed [31:0] r_oq [4];
    logic               r_oupd;

    t_uop               w_u;
    logic               w_we;
    t_ra                w_wa;
    t_word              w_wd;
    logic signed [79:0] w_sat;
    logic signed [79:0] w_term;
    logic signed [79:0] w_tc;
    logic signed [79:0] w_accn;
    logic signed [79:0] w_post;
    logic [4:0]         w_pk;
    logic               w_neg;
    logic [63:0]        w_abs;
    logic [63:0]        w_num;
    logic [31:0]        w_den;
    logic               w_dstart;
    logic               w_ddone;
    logic [32:0]        w_quot;
    logic signed [79:0] w_qs;
    logic               w_sstart;
    logic               w_sdone;
    logic [31:0]        w_root;
    logic               w_out_free;

    assign w_u = ucode(r_pc);

    // accumulate stage: round the product, weight it, add, finish
    always_comb begin
        case (w_u.pre)
            PR_12:   w_pk = 5'd12;
            PR_16:   w_pk = 5'd16;
            PR_30:   w_pk = 5'd30;
            default: w_pk = 5'd0;
        endcase
        w_term = rnd_shr({{6{r_prod[73]}}, r_prod}, w_pk);
        case (w_u.coef)
            CF_M1:   w_tc = -w_term;
            CF_P2:   w_tc = w_term <<< 1;
            CF_M2:   w_tc = -(w_term <<< 1);
            CF_P4:   w_tc = w_term <<< 2;
            CF_M4:   w_tc = -(w_term <<< 2);
            CF_P8:   w_tc = w_term <<< 3;
            default: w_tc = w_term;
        endcase
        w_accn = (w_u.first ? 80'sd0 : r_acc) + w_tc;
        case (w_u.post)
            PO_R6:   w_post = rnd_shr(w_accn, 5'd6);
            PO_R13:  w_post = rnd_shr(w_accn, 5'd13);
            PO_L30:  w_post = w_accn <<< 30;
            default: w_post = w_accn;
        endcase
    end

    // divider operands: magnitude scaled and pre-rounded by half the divisor
    always_comb begin
        w_neg = r_rda[63];
        w_abs = w_neg ? 64'(-r_rda) : r_rda;
        w_den = r_rdb[31:0];
        case (w_u.dk)
            DK_24:   w_num = (w_abs << 24) + {33'd0, w_den[31:1]};
            DK_30:   w_num = (w_abs << 30) + {33'd0, w_den[31:1]};
            default: w_num = (w_abs << 45) + {33'd0, w_den[31:1]};
        endcase
        w_qs = w_neg ? -$signed({47'd0, w_quot}) : $signed({47'd0, w_quot});
    end

    assign w_dstart = (r_st == S_EX) && (w_u.op == OP_DIV) && (w_den != 32'd0);
    assign w_sstart = (r_st == S_EX) && (w_u.op == OP_SQRT);

    imu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_num),
        .i_divisor  (w_den),
        .o_done     (w_ddone),
        .o_quot     (w_quot)
    );

    imu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sstart),
        .i_val   (r_rda),
        .o_done  (w_sdone),
        .o_root  (w_root)
    );

    // register file write port
    always_comb begin
        w_we  = 1'b0;
        w_wa  = w_u.rd;
        w_wd  = '0;
        w_sat = '0;
        case (r_st)
            S_LOAD: begin
                w_we = 1'b1;
                w_wa = (r_lc == LOAD_LAST) ? R_ONE : t_ra'(r_lc);
                case (r_lc)
                    4'd0:    w_wd = {{48{r_gx[15]}}, r_gx};
                    4'd1:    w_wd = {{48{r_gy[15]}}, r_gy};
                    4'd2:    w_wd = {{48{r_gz[15]}}, r_gz};
                    4'd3:    w_wd = {{48{r_ax[15]}}, r_ax};
                    4'd4:    w_wd = {{48{r_ay[15]}}, r_ay};
                    4'd5:    w_wd = {{48{r_az[15]}}, r_az};
                    4'd6:    w_wd = {48'd0, r_dt};
                    4'd7:    w_wd = {48'd0, r_beta};
                    4'd8:    w_wd = {{32{r_q[0][31]}}, r_q[0]};
                    4'd9:    w_wd = {{32{r_q[1][31]}}, r_q[1]};
                    4'd10:   w_wd = {{32{r_q[2][31]}}, r_q[2]};
                    4'd11:   w_wd = {{32{r_q[3][31]}}, r_q[3]};
                    default: w_wd = 64'd1;
                endcase
            end
            S_AC: begin
                w_we  = w_u.last;
                w_sat = sat_v(w_post, w_u.sat);
                w_wd  = w_sat[63:0];
            end
            S_EX: begin
                // a zero divisor passes the numerator through the clamp
                w_we  = (w_u.op == OP_DIV) && (w_den == 32'd0);
                w_sat = sat_v({{16{r_rda[63]}}, r_rda}, w_u.sat);
                w_wd  = w_sat[63:0];
            end
            S_WDV: begin
                w_we  = w_ddone;
                w_sat = sat_v(w_qs, w_u.sat);
                w_wd  = w_sat[63:0];
            end
            S_WSQ: begin
                w_we = w_sdone;
                w_wd = {32'd0, w_root};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // register file, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_rf[w_wa] <= w_wd;
        end
        r_rda <= r_rf[w_u.ra];
        r_rdb <= r_rf[w_u.rb];
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        if (r_st == S_EX) begin
            r_prod <= $signed(r_rda[36:0]) * $signed(r_rdb[36:0]);
        end
        if (r_st == S_AC) begin
            r_acc <= w_accn;
        end
    end

    // captured sample
    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_gx <= i_sample.gyro_x;
            r_gy <= i_sample.gyro_y;
            r_gz <= i_sample.gyro_z;
            r_ax <= i_sample.accel_x;
            r_ay <= i_sample.accel_y;
            r_az <= i_sample.accel_z;
            r_dt <= i_sample.time_step;
        end
    end

    assign w_out_free = !r_ov || o_result.ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_pc  <= '0;
            r_lc  <= '0;
            r_upd <= 1'b0;
            r_q[0] <= 32'sd1 <<< 30;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_st <= S_LOAD;
                        r_lc <= '0;
                        r_pc <= '0;
                    end
                end
                S_LOAD: begin
                    r_lc <= r_lc + 4'd1;
                    if (r_lc == LOAD_LAST) begin
                        r_st <= S_RD;
                    end
                end
                S_RD: begin
                    r_st <= S_EX;
                end
                S_EX: begin
                    case (w_u.op)
                        OP_MAC: r_st <= S_AC;
                        OP_SQRT: r_st <= S_WSQ;
                        OP_DIV: begin
                            if (w_den == 32'd0) begin
                                r_pc <= r_pc + 7'd1;
                                r_st <= S_RD;
                            end else begin
                                r_st <= S_WDV;
                            end
                        end
                        OP_SKIPZ: begin
                            if (r_rda == 64'd0) begin
                                r_upd <= 1'b0;
                                r_st  <= S_OUT;
                            end else begin
                                r_pc <= r_pc + 7'd1;
                                r_st <= S_RD;
                            end
                        end
                        OP_STQ: begin
                            r_q[w_u.rd[1:0]] <= r_rda[31:0];
                            r_pc <= r_pc + 7'd1;
                            r_st <= S_RD;
                        end
                        default: begin
                            r_upd <= 1'b1;
                            r_st  <= S_OUT;
                        end
                    endcase
                end
                S_AC: begin
                    r_pc <= r_pc + 7'd1;
                    r_st <= S_RD;
                end
                S_WDV: begin
                    if (w_ddone) begin
                        r_pc <= r_pc + 7'd1;
                        r_st <= S_RD;
                    end
                end
                S_WSQ: begin
                    if (w_sdone) begin
                        r_pc <= r_pc + 7'd1;
                        r_st <= S_RD;
                    end
                end
                default: begin
                    if (w_out_free) begin
                        r_st <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == S_OUT && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && w_out_free) begin
            r_oq   <= r_q;
            r_oupd <= r_upd;
        end
    end

    // gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= BETA_RESET;
        end else if (i_cfg.valid) begin
            r_beta <= i_cfg.beta_gain;
        end
    end

    assign i_cfg.ready      = 1'b1;
    assign i_sample.ready   = (r_st == S_IDLE);
    assign o_result.valid   = r_ov;
    assign o_result.quat_w  = r_oq[0];
    assign o_result.quat_x  = r_oq[1];
    assign o_result.quat_y  = r_oq[2];
    assign o_result.quat_z  = r_oq[3];
    assign o_result.updated = r_oupd;

endmodule
